>>> src/att_pkg.sv
// att_pkg: shared constants, codes and types of the allocation tracker table
// no dependencies; compiled first

package att_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int ADDR_W        = 32;
    localparam int SIZE_W        = 31;
    localparam int TOT_W         = 32;
    localparam int OUT_CNT_W     = 7;
    localparam int STATUS_W      = 2;
    // exact sum of every stored size never overflows this width
    localparam int BYTES_W       = SIZE_W + $clog2(TABLE_ENTRIES + 1);

    typedef enum logic {
        KIND_ALLOC = 1'b0,
        KIND_FREE  = 1'b1
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_UNKNOWN = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_UPDATE
    } t_state;

    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] address;
        logic [SIZE_W-1:0] size;
    } t_evt;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [SIZE_W-1:0] size;
    } t_entry;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic scan;
        logic commit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic last;
        logic out_free;
    } t_stat;

endpackage

>>> src/att_if.sv
// att_evt_if and att_res_if: valid/ready channels of the allocation tracker
// depends on att_pkg for field widths

interface att_evt_if;
    import att_pkg::*;

    logic              valid;
    logic              ready;
    logic              kind;
    logic [ADDR_W-1:0] address;
    logic [SIZE_W-1:0] size;

    modport source (output valid, kind, address, size, input ready);
    modport sink   (input valid, kind, address, size, output ready);
endinterface

interface att_res_if;
    import att_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [TOT_W-1:0]     live_total;
    logic [TOT_W-1:0]     peak_total;
    logic [OUT_CNT_W-1:0] entry_count;
    logic [TOT_W-1:0]     entry_bytes;
    logic [STATUS_W-1:0]  status;

    modport source (output valid, live_total, peak_total, entry_count, entry_bytes, status,
                    input ready);
    modport sink   (input valid, live_total, peak_total, entry_count, entry_bytes, status,
                    output ready);
endinterface

>>> src/att_ctrl.sv
// att_ctrl: sequencer of the allocation tracker (accept, scan, update)
// depends on att_pkg

module att_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  att_pkg::t_stat i_stat,
    output att_pkg::t_cmd  o_cmd
);
    import att_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_stat.last) n_state = S_LAST;
            end
            S_LAST: begin
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.start = i_in_valid;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            S_LAST: begin
                o_cmd = '0;
            end
            S_UPDATE: begin
                o_cmd.commit = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

>>> src/att_datapath.sv
// att_datapath: entry memory, valid bits, key scan and running totals
// depends on att_pkg and att_res_if

module att_datapath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  att_pkg::t_evt  i_evt,
    input  att_pkg::t_cmd  i_cmd,
    output att_pkg::t_stat o_stat,
    att_res_if.source      o_res
);
    import att_pkg::*;

    t_entry                 r_mem [TABLE_ENTRIES];
    t_entry                 r_rdata;
    logic [TABLE_ENTRIES-1:0] r_valid, n_valid;
    t_evt                   r_evt;

    logic [IDX_W-1:0]  r_scan_idx;
    logic [IDX_W-1:0]  r_cmp_idx;
    logic              r_cmp_en;
    logic              r_hit;
    logic [IDX_W-1:0]  r_hit_idx;
    logic [SIZE_W-1:0] r_old_size;
    logic              r_empty;
    logic [IDX_W-1:0]  r_empty_idx;

    logic [TOT_W-1:0]   r_live, n_live;
    logic [TOT_W-1:0]   r_peak, n_peak;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [BYTES_W-1:0] r_bytes, n_bytes;
    t_status            r_status, n_status;
    logic               r_out_valid;

    logic              cmp_hit;
    logic              cmp_free;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic [TOT_W:0]    live_sum;
    logic [TOT_W-1:0]  live_alloc;
    logic [TOT_W-1:0]  old_tot;
    logic [TOT_W-1:0]  live_free;
    logic [BYTES_W-1:0] bytes_less;
    logic [BYTES_W-1:0] bytes_add;

    // compare stage, aligned with registered read data
    assign cmp_hit  = r_cmp_en && r_valid[r_cmp_idx] && (r_rdata.address == r_evt.address);
    assign cmp_free = r_cmp_en && !r_valid[r_cmp_idx];

    // entry memory: one read and one write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan) r_rdata <= r_mem[r_scan_idx];
        if (wr_en) r_mem[wr_idx] <= '{address: r_evt.address, size: r_evt.size};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) r_evt <= i_evt;
        if (i_cmd.scan) r_cmp_idx <= r_scan_idx;
        if (cmp_hit) begin
            r_hit_idx  <= r_cmp_idx;
            r_old_size <= r_rdata.size;
        end
        if (cmp_free && !r_empty) r_empty_idx <= r_cmp_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_idx <= '0;
            r_cmp_en   <= 1'b0;
            r_hit      <= 1'b0;
            r_empty    <= 1'b0;
        end else begin
            r_cmp_en <= i_cmd.scan;
            if (i_cmd.start) begin
                r_scan_idx <= '0;
                r_hit      <= 1'b0;
                r_empty    <= 1'b0;
            end else begin
                if (i_cmd.scan) r_scan_idx <= r_scan_idx + IDX_W'(1);
                if (cmp_hit) r_hit <= 1'b1;
                if (cmp_free) r_empty <= 1'b1;
            end
        end
    end

    // update arithmetic
    assign live_sum   = {1'b0, r_live} + (TOT_W+1)'(r_evt.size);
    assign live_alloc = live_sum[TOT_W] ? '1 : live_sum[TOT_W-1:0];
    assign old_tot    = TOT_W'(r_old_size);
    assign live_free  = (r_live >= old_tot) ? (r_live - old_tot) : '0;
    assign bytes_less = r_bytes - (r_hit ? BYTES_W'(r_old_size) : '0);
    assign bytes_add  = bytes_less + BYTES_W'(r_evt.size);

    always_comb begin
        n_valid  = r_valid;
        n_live   = r_live;
        n_peak   = r_peak;
        n_count  = r_count;
        n_bytes  = r_bytes;
        n_status = r_status;
        wr_en    = 1'b0;
        wr_idx   = r_hit_idx;
        if (i_cmd.commit) begin
            n_status = ST_OK;
            if (r_evt.kind == KIND_ALLOC) begin
                n_live = live_alloc;
                n_peak = (live_alloc > r_peak) ? live_alloc : r_peak;
                if (r_hit) begin
                    // overwrite: old size stays in the live total
                    wr_en   = 1'b1;
                    wr_idx  = r_hit_idx;
                    n_bytes = bytes_add;
                end else if (r_empty) begin
                    wr_en                = 1'b1;
                    wr_idx               = r_empty_idx;
                    n_valid[r_empty_idx] = 1'b1;
                    n_count              = r_count + CNT_W'(1);
                    n_bytes              = bytes_add;
                end else begin
                    n_status = ST_FULL;
                end
            end else if (r_hit) begin
                n_live             = live_free;
                n_valid[r_hit_idx] = 1'b0;
                n_count            = r_count - CNT_W'(1);
                n_bytes            = bytes_less;
            end else begin
                n_status = ST_UNKNOWN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_live      <= '0;
            r_peak      <= '0;
            r_count     <= '0;
            r_bytes     <= '0;
            r_status    <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_valid  <= n_valid;
            r_live   <= n_live;
            r_peak   <= n_peak;
            r_count  <= n_count;
            r_bytes  <= n_bytes;
            r_status <= n_status;
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // totals only change at commit, so they hold the pending result
    assign o_res.valid       = r_out_valid;
    assign o_res.live_total  = r_live;
    assign o_res.peak_total  = r_peak;
    assign o_res.entry_count = OUT_CNT_W'(r_count);
    assign o_res.entry_bytes = (r_bytes > BYTES_W'(32'hFFFF_FFFF)) ? '1 : TOT_W'(r_bytes);
    assign o_res.status      = r_status;

    assign o_stat.last     = (r_scan_idx == IDX_W'(TABLE_ENTRIES - 1));
    assign o_stat.out_free = !r_out_valid || o_res.ready;

    a_count_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == CNT_W'($countones(r_valid)))
        else $error("entry count differs from number of valid slots");

    a_peak_covers_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_peak >= r_live)
        else $error("peak total below live total");

    a_commit_needs_free_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> (!r_out_valid || o_res.ready))
        else $error("commit while previous result still pending");

    a_totals_hold_while_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready) |=> ($stable(r_live) && $stable(r_bytes)))
        else $error("totals changed under a pending result");

endmodule

>>> src/allocation_tracker_table.sv
// allocation_tracker_table: top level of the live allocation tracker
// depends on att_pkg, att_if, att_ctrl and att_datapath

// Keeps up to TABLE_ENTRIES live allocations keyed by address, with a
// saturating live byte total, its peak, the number of held entries and the
// saturated sum of their sizes. Every event on i_evt gives exactly one result
// on o_res carrying the totals after that event and a status: ok, free of an
// unknown address, or table full (the allocation is then not stored, though
// live and peak totals still move). The entry memory has one read port and
// the key and free-slot search reads one entry a cycle, followed by a compare
// step (S_LAST) and an update step (S_UPDATE). A new event transfers in the
// cycle after the update, and none is taken before the update of the last one.
// A result waiting on o_res does not stop the next event from being taken;
// only its update waits for the output to drain. The table is empty right
// after reset with no clearing pass, valid bits sit in flip-flops.

module allocation_tracker_table (
    input  logic      i_clk,
    input  logic      i_rst_n,
    att_evt_if.sink   i_evt,
    att_res_if.source o_res
);
    import att_pkg::*;

    t_evt  evt;
    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;

    // event payload into one word for the datapath
    assign evt = '{kind: i_evt.kind, address: i_evt.address, size: i_evt.size};
    assign i_evt.ready = in_ready;

    // sequencer: idle, scan of all entries, compare, update
    att_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_evt.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // table memory, search and totals; drives the result channel
    att_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (evt),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_res   (o_res)
    );

endmodule

>>> tb/sv/att_table_checker.sv
// att_table_checker: watches the event and result channels of the tracker,
// predicts every result from its own copy of the table, compares field by field
// depends on att_pkg and the channel interfaces in att_if
`timescale 1ns / 1ps

module att_table_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    att_evt_if   i_evt,
    att_res_if   i_res,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_results,
    output int   o_full_drops,
    output int   o_unknown_frees
);
    import att_pkg::*;

    typedef struct packed {
        logic [TOT_W-1:0]     live;
        logic [TOT_W-1:0]     peak;
        logic [OUT_CNT_W-1:0] count;
        logic [TOT_W-1:0]     bytes;
        t_status              status;
    } t_totals;

    // shadow table and running totals
    logic              held_valid [TABLE_ENTRIES];
    logic [ADDR_W-1:0] held_addr  [TABLE_ENTRIES];
    logic [SIZE_W-1:0] held_size  [TABLE_ENTRIES];
    logic [TOT_W-1:0]  live_bytes;
    logic [TOT_W-1:0]  peak_bytes;

    t_totals expected_totals_q [$];
    int      mismatch_total;
    int      result_total;
    int      full_total;
    int      unknown_total;

    function automatic int find_held(input logic [ADDR_W-1:0] key);
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (held_valid[i] && held_addr[i] == key) return i;
        end
        return -1;
    endfunction

    function automatic int find_empty();
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (!held_valid[i]) return i;
        end
        return -1;
    endfunction

    task automatic track_event(input logic kind, input logic [ADDR_W-1:0] key,
                               input logic [SIZE_W-1:0] bytes, output t_totals t);
        logic [TOT_W:0] sum;
        logic [63:0]    stored;
        int             slot;
        int             n;
        t.status = ST_OK;
        if (kind == KIND_ALLOC) begin
            sum        = {1'b0, live_bytes} + bytes;
            live_bytes = sum[TOT_W] ? '1 : sum[TOT_W-1:0];
            if (live_bytes > peak_bytes) peak_bytes = live_bytes;
            slot = find_held(key);
            if (slot < 0) slot = find_empty();
            if (slot < 0) begin
                t.status = ST_FULL;
            end else begin
                held_valid[slot] = 1'b1;
                held_addr[slot]  = key;
                held_size[slot]  = bytes;
            end
        end else begin
            slot = find_held(key);
            if (slot < 0) begin
                t.status = ST_UNKNOWN;
            end else begin
                // saturate at zero, only reachable after an earlier overflow
                live_bytes = (live_bytes >= held_size[slot]) ?
                             live_bytes - held_size[slot] : '0;
                held_valid[slot] = 1'b0;
            end
        end
        stored = '0;
        n      = 0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (held_valid[i]) begin
                stored += held_size[i];
                n++;
            end
        end
        t.bytes = (stored > 64'h0000_0000_FFFF_FFFF) ? '1 : stored[TOT_W-1:0];
        t.count = n[OUT_CNT_W-1:0];
        t.live  = live_bytes;
        t.peak  = peak_bytes;
    endtask

    task automatic check_field(input string name, input logic [TOT_W-1:0] want,
                               input logic [TOT_W-1:0] seen);
        if (seen !== want) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, seen);
            mismatch_total++;
        end
    endtask

    always @(posedge i_clk) begin
        t_totals want;
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) held_valid[i] = 1'b0;
            live_bytes = '0;
            peak_bytes = '0;
            expected_totals_q.delete();
        end else begin
            // result first: a result in the same cycle as an event is older
            if (i_res.valid && i_res.ready) begin
                result_total++;
                if (expected_totals_q.size() == 0) begin
                    $error("result transfer with no event waiting");
                    mismatch_total++;
                end else begin
                    want = expected_totals_q.pop_front();
                    check_field("live_total", want.live, i_res.live_total);
                    check_field("peak_total", want.peak, i_res.peak_total);
                    check_field("entry_count", TOT_W'(want.count), TOT_W'(i_res.entry_count));
                    check_field("entry_bytes", want.bytes, i_res.entry_bytes);
                    check_field("status", TOT_W'(want.status), TOT_W'(i_res.status));
                end
            end
            if (i_evt.valid && i_evt.ready) begin
                track_event(i_evt.kind, i_evt.address, i_evt.size, want);
                if (want.status == ST_FULL)    full_total++;
                if (want.status == ST_UNKNOWN) unknown_total++;
                expected_totals_q.push_back(want);
            end
        end
        o_fail_count    <= mismatch_total;
        o_pending       <= expected_totals_q.size();
        o_results       <= result_total;
        o_full_drops    <= full_total;
        o_unknown_frees <= unknown_total;
    end

endmodule

>>> tb/sv/allocation_tracker_table_tb.sv
// allocation_tracker_table_tb: stimulus, flow control and verdict for the tracker
// depends on att_pkg, att_if, allocation_tracker_table and att_table_checker
`timescale 1ns / 1ps

module allocation_tracker_table_tb;
    import att_pkg::*;

    localparam int HALF_PERIOD  = 4;
    localparam int MAX_GAP      = 14;
    // long receiver hold-off so the block fills and backs up its input
    localparam int HOLD_CYCLES  = 500;
    // no transfer for this long means the block is stuck
    localparam int IDLE_LIMIT   = 4000;
    localparam int PHASES       = 17;
    localparam int PHASE_ITEMS  = 100;
    // more addresses than slots so the table can run full
    localparam int POOL_SIZE    = 72;
    // drain wait at the end, scaled with TABLE_ENTRIES
    localparam int DRAIN_CYCLES = 2 * (TABLE_ENTRIES + 4);

    logic i_clk = 1'b0;
    logic i_rst_n;

    att_evt_if evt_ch ();
    att_res_if res_ch ();

    int fail_count;
    int pending;
    int results_seen;
    int full_drops;
    int unknown_frees;
    int sent_count;
    int idle_cycles;

    logic [ADDR_W-1:0] addr_pool [POOL_SIZE];

    always begin
        #(HALF_PERIOD) i_clk = 1'b1;
        #(HALF_PERIOD) i_clk = 1'b0;
    end

    allocation_tracker_table u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (evt_ch),
        .o_res   (res_ch)
    );

    att_table_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_evt           (evt_ch),
        .i_res           (res_ch),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_results       (results_seen),
        .o_full_drops    (full_drops),
        .o_unknown_frees (unknown_frees)
    );

    // offer one event and hold it until its transfer; valid only drops when
    // a gap is drawn, so back-to-back events keep it high
    task automatic send_event(input t_kind kind, input logic [ADDR_W-1:0] addr,
                              input logic [SIZE_W-1:0] bytes, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            evt_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        evt_ch.valid   <= 1'b1;
        evt_ch.kind    <= kind;
        evt_ch.address <= addr;
        evt_ch.size    <= bytes;
        do @(posedge i_clk); while (!evt_ch.ready);
        sent_count++;
    endtask

    // sender: reset, directed events, then random phases
    initial begin
        int                p;
        int                i;
        int                alloc_pct;
        int                pool_n;
        bit                burst;
        t_kind             kind;
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] bytes;

        evt_ch.valid   <= 1'b0;
        evt_ch.kind    <= KIND_ALLOC;
        evt_ch.address <= '0;
        evt_ch.size    <= '0;
        i_rst_n        <= 1'b0;
        sent_count = 0;

        // address pool with both extremes of the key
        addr_pool[0] = '0;
        addr_pool[1] = '1;
        for (i = 2; i < POOL_SIZE; i++) addr_pool[i] = $urandom();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: small totals first, while live and peak can still move
        send_event(KIND_ALLOC, 32'h0000_0000, 31'd0, 1'b0);   // key zero, size zero
        send_event(KIND_ALLOC, 32'hFFFF_FFFF, 31'd100, 1'b0); // top key
        send_event(KIND_ALLOC, 32'h0000_1234, 31'd50, 1'b0);  // peak rises
        send_event(KIND_FREE,  32'h0000_1234, '1, 1'b0);      // size field ignored on free
        send_event(KIND_FREE,  32'hDEAD_BEEF, 31'd0, 1'b0);   // free of unknown key
        send_event(KIND_ALLOC, 32'hFFFF_FFFF, 31'd7, 1'b0);   // overwrite, old size stays live
        send_event(KIND_FREE,  32'hFFFF_FFFF, 31'd0, 1'b0);
        send_event(KIND_FREE,  32'h0000_0000, 31'd0, 1'b0);
        send_event(KIND_FREE,  32'h0000_0000, 31'd0, 1'b0);   // already gone
        // three largest sizes: live total and entry sum saturate
        send_event(KIND_ALLOC, 32'h8000_0000, '1, 1'b1);
        send_event(KIND_ALLOC, 32'h5555_5555, '1, 1'b1);
        send_event(KIND_ALLOC, 32'hAAAA_AAAA, '1, 1'b1);
        // freeing them walks live below the stored sum, last one clamps at zero
        send_event(KIND_FREE,  32'h8000_0000, 31'd0, 1'b0);
        send_event(KIND_FREE,  32'h5555_5555, 31'd0, 1'b0);
        send_event(KIND_FREE,  32'hAAAA_AAAA, 31'd0, 1'b0);

        // random phases: fill-heavy, mixed and drain-heavy, over a wide or
        // a narrow set of keys; narrow sets give many hits and overwrites
        for (p = 0; p < PHASES; p++) begin
            case (p % 8)
                0, 1:    begin alloc_pct = 95; pool_n = POOL_SIZE; end
                2:       begin alloc_pct = 55; pool_n = 8;         end
                3:       begin alloc_pct = 15; pool_n = POOL_SIZE; end
                4, 5:    begin alloc_pct = 92; pool_n = POOL_SIZE; end
                6:       begin alloc_pct = 45; pool_n = 16;        end
                default: begin alloc_pct = 10; pool_n = POOL_SIZE; end
            endcase
            // some phases run without any sender gaps
            burst = ((p % 5) == 3);
            for (i = 0; i < PHASE_ITEMS; i++) begin
                case (p % 4)
                    0:       bytes = SIZE_W'($urandom_range(0, 255));
                    1:       bytes = SIZE_W'($urandom_range(0, 1 << 20));
                    2:       bytes = SIZE_W'($urandom());
                    default: bytes = $urandom_range(0, 1) ? '1 :
                                     SIZE_W'($urandom_range(0, 15));
                endcase
                if ($urandom_range(0, 99) < 8) begin
                    // noise: free of a random key, almost never held
                    addr = $urandom();
                    send_event(KIND_FREE, addr, bytes, burst);
                end else begin
                    kind = ($urandom_range(0, 99) < alloc_pct) ? KIND_ALLOC : KIND_FREE;
                    addr = addr_pool[$urandom_range(0, pool_n - 1)];
                    send_event(kind, addr, bytes, burst);
                end
            end
        end
        evt_ch.valid <= 1'b0;

        // wait for every result, then a little longer for strays
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d events, checked %0d results", sent_count, results_seen);
        $display("covered %0d table-full drops and %0d frees of unknown keys",
                 full_drops, unknown_frees);
        if (fail_count == 0) begin
            $display("allocation_tracker_table_tb passed");
        end else begin
            $display("allocation_tracker_table_tb failed");
        end
        $finish;
    end

    // receiver: random stalls, stall-free stretches, and two long hold-offs
    initial begin
        int n;
        int stall;
        bit burst;
        n = 0;
        res_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            burst = (((n / 80) % 5) == 2);
            stall = burst ? 0 : $urandom_range(0, MAX_GAP);
            // hold off while the sender keeps offering, block backs up
            if (n == 250 || n == 1000) stall = HOLD_CYCLES;
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
            n++;
        end
    end

    // watchdog on cycles with no transfer on either channel
    initial begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (evt_ch.valid && evt_ch.ready) ||
                (res_ch.valid && res_ch.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
        $display("allocation_tracker_table_tb failed");
        $finish;
    end

endmodule

>>> sim.f
src/att_pkg.sv
src/att_if.sv
src/att_ctrl.sv
src/att_datapath.sv
src/allocation_tracker_table.sv
tb/sv/att_table_checker.sv
tb/sv/allocation_tracker_table_tb.sv
